/* rtl/etp_pkg.sv */
// shared types, constants and helper function for the euclidean trigger pattern block
package etp_pkg;

	localparam int MAX_STEPS = 32;
	localparam int PAT_W     = MAX_STEPS;
	localparam int IDX_W     = $clog2(MAX_STEPS);
	localparam int LEN_W     = 6;
	localparam int HITS_W    = 6;
	localparam int STEP_W    = 16;
	localparam int AMT_W     = 7;
	localparam int DIV_W     = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int PROD_W    = 2 * LEN_W;
	localparam int POS_W     = DIV_W + 1;
	localparam int LEN_RESET = 16;
	localparam int J_INIT    = 2;

	typedef enum logic [1:0] {
		OP_GEN  = 2'd0,
		OP_READ = 2'd1,
		OP_ROT  = 2'd2,
		OP_INV  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_INVERT,
		CMD_DIV_IDX,
		CMD_DIV_AMT,
		CMD_READ,
		CMD_ROT,
		CMD_GEN_INIT,
		CMD_DIV_M,
		CMD_PASSES,
		CMD_PASS_BEGIN,
		CMD_MOVE,
		CMD_PASS_END,
		CMD_FIN_BEGIN,
		CMD_PROD1,
		CMD_PROD2,
		CMD_DIV_A,
		CMD_Q1_DIV_B,
		CMD_FIN_MOVE,
		CMD_DONE
	} dp_cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_IDX_WAIT,
		S_AMT_WAIT,
		S_GEN_INIT,
		S_GEN_CHECK,
		S_M_WAIT,
		S_PASS_CHECK,
		S_MOVE,
		S_FIN_CHECK,
		S_PROD2,
		S_DIV_A,
		S_WAIT_A,
		S_WAIT_B,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic h_trivial;
		logic pass_more;
		logic i_lt_l;
		logic div_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [PAT_W-1:0] len_mask(input logic [LEN_W-1:0] cnt);
		logic [PAT_W:0] t;
		t = ({{PAT_W{1'b0}}, 1'b1} << cnt) - {{PAT_W{1'b0}}, 1'b1};
		return t[PAT_W-1:0];
	endfunction

endpackage

/* rtl/etp_if.sv */
// valid/ready channel interfaces for input items and result items
interface etp_in_if import etp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              op;
	logic [HITS_W-1:0]       hits;
	logic [STEP_W-1:0]       step_index;
	logic signed [AMT_W-1:0] shift_amount;

	modport source (output valid, output op, output hits, output step_index,
		output shift_amount, input ready);
	modport sink (input valid, input op, input hits, input step_index,
		input shift_amount, output ready);
endinterface

interface etp_out_if import etp_pkg::*;;
	logic             valid;
	logic             ready;
	logic             trigger;
	logic [PAT_W-1:0] pattern;

	modport source (output valid, output trigger, output pattern, input ready);
	modport sink (input valid, input trigger, input pattern, output ready);
endinterface

/* rtl/euclidean_trigger_pattern_top.sv */
// top level: length register, controller and datapath of the euclidean trigger pattern block
// one item at a time, next item taken the cycle after the result is loaded
// invert works on the pattern directly; read and rotate each take one division on the divider
// generate: trivial for no hits or all hits, else passes of spreading moves, then final moves
// with two divisions each on the shared divider
// reset: pattern all zeros, length 16, no item pending
module euclidean_trigger_pattern_top import etp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	etp_in_if.sink           req,
	etp_out_if.source        rsp,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data
);

	logic [LEN_W-1:0] pattern_length_q;
	logic [LEN_W-1:0] n_eff;
	dp_cmd_t          cmd;
	dp_status_t       status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pattern_length_q <= LEN_W'(LEN_RESET);
		else if (cfg_we)
			pattern_length_q <= cfg_data;
	end

	always_comb begin
		if (pattern_length_q == '0)
			n_eff = LEN_W'(1);
		else if (pattern_length_q > LEN_W'(MAX_STEPS))
			n_eff = LEN_W'(MAX_STEPS);
		else
			n_eff = pattern_length_q;
	end

	etp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	etp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.n               (n_eff),
		.in_op           (req.op),
		.in_hits         (req.hits),
		.in_step_index   (req.step_index),
		.in_shift_amount (req.shift_amount),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_trigger     (rsp.trigger),
		.out_pattern     (rsp.pattern)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while another is in work");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_DONE |-> !rsp.valid || rsp.ready)
		else $error("result written over a waiting result");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.pattern & ~len_mask(n_eff)) == '0)
		else $error("pattern holds steps beyond the length");

	a_trig_set: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.trigger |-> rsp.pattern != '0)
		else $error("trigger set from an empty pattern");

endmodule

/* rtl/etp_div.sv */
// restoring divider, one quotient bit per cycle
module etp_div import etp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic [LEN_W-1:0] remainder,
	output logic             done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     quo_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     dsr_q;
	logic [LEN_W:0]       rem_sh;
	logic [LEN_W:0]       rem_nx;
	logic                 ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		ge     = rem_sh >= {1'b0, dsr_q};
		rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 1'b1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_nx[LEN_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

/* rtl/etp_dp.sv */
// datapath: pattern store, generate bookkeeping, invert, rotate, read and output register
module etp_dp import etp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_status_t              status,
	input  logic [LEN_W-1:0]        n,
	input  logic [1:0]              in_op,
	input  logic [HITS_W-1:0]       in_hits,
	input  logic [STEP_W-1:0]       in_step_index,
	input  logic signed [AMT_W-1:0] in_shift_amount,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_trigger,
	output logic [PAT_W-1:0]        out_pattern
);

	logic [PAT_W-1:0]        s_q;
	logic                    out_valid_q;
	logic                    out_trigger_q;
	logic [PAT_W-1:0]        out_pattern_q;
	op_t                     op_q;
	logic [HITS_W-1:0]       hits_q;
	logic [STEP_W-1:0]       idx_q;
	logic signed [AMT_W-1:0] amt_q;
	logic                    trig_q;
	logic [LEN_W-1:0]        h_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        j_q;
	logic [LEN_W-1:0]        k_q;
	logic [LEN_W-1:0]        passes_q;
	logic [LEN_W-1:0]        i_q;
	logic signed [LEN_W:0]   l_q;
	logic [PROD_W-1:0]       ij_q;
	logic [DIV_W-1:0]        ijh_q;
	logic [DIV_W-1:0]        q1_q;

	logic [PAT_W-1:0]        mask;
	logic [LEN_W-1:0]        h_init;
	logic [LEN_W-1:0]        diff_u;
	logic [LEN_W-1:0]        m_val;
	logic signed [LEN_W:0]   diff_s;
	logic signed [LEN_W:0]   h_s;
	logic signed [LEN_W:0]   l_val;
	logic [PROD_W-1:0]       ij_val;
	logic [PROD_W+LEN_W-1:0] ijh_val;
	logic [AMT_W-1:0]        amt_mag;
	logic [LEN_W-1:0]        rot_r;
	logic [PAT_W-1:0]        rot_val;
	logic signed [POS_W-1:0] pos_move;
	logic signed [POS_W-1:0] pos_fin;
	logic                    div_start;
	logic [DIV_W-1:0]        div_dividend;
	logic [LEN_W-1:0]        div_divisor;
	logic [DIV_W-1:0]        div_q;
	logic [LEN_W-1:0]        div_r;
	logic                    div_done;

	function automatic logic [PAT_W-1:0] move_last(input logic [PAT_W-1:0] s,
		input logic [LEN_W-1:0] len, input logic signed [POS_W-1:0] pos);
		logic [PAT_W-1:0] r;
		logic             carried;
		int               p;
		int               nn;
		p  = int'(pos);
		nn = int'(len);
		r  = s;
		carried = s[IDX_W'(nn - 1)];
		if (p >= 0 && p + 1 < nn) begin
			for (int k = 0; k < PAT_W; k++) begin
				if (k == p + 1)
					r[k] = carried;
				else if (k > p + 1 && k < nn)
					r[k] = s[k-1];
			end
		end
		return r;
	endfunction

	etp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	always_comb begin
		mask    = len_mask(n);
		h_init  = (hits_q > n) ? n : hits_q;
		diff_u  = len_q - h_q;
		m_val   = (h_q < diff_u) ? h_q : diff_u;
		diff_s  = $signed({1'b0, len_q}) - $signed({1'b0, h_q});
		h_s     = $signed({1'b0, h_q});
		l_val   = (h_s < diff_s) ? h_s : diff_s;
		ij_val  = {{LEN_W{1'b0}}, i_q} * {{LEN_W{1'b0}}, j_q};
		ijh_val = {{LEN_W{1'b0}}, ij_q} * {{PROD_W{1'b0}}, h_q};
		amt_mag = amt_q[AMT_W-1] ? AMT_W'(-amt_q) : AMT_W'(amt_q);
		rot_r   = (amt_q[AMT_W-1] && div_r != '0) ? n - div_r : div_r;
		rot_val = ((s_q >> rot_r) | (s_q << (n - rot_r))) & mask;
		pos_move = $signed({{(POS_W-PROD_W){1'b0}}, ij_val});
		pos_fin  = $signed({1'b0, q1_q}) - $signed({1'b0, div_q});
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = n;
		unique case (cmd)
			CMD_DIV_IDX: begin
				div_start    = 1'b1;
				div_dividend = idx_q;
			end
			CMD_DIV_AMT: begin
				div_start    = 1'b1;
				div_dividend = {{(DIV_W-AMT_W){1'b0}}, amt_mag};
			end
			CMD_DIV_M: begin
				div_start    = 1'b1;
				div_dividend = {{(DIV_W-LEN_W){1'b0}}, len_q};
				div_divisor  = m_val;
			end
			CMD_DIV_A: begin
				div_start    = 1'b1;
				div_dividend = ijh_q;
				div_divisor  = l_q[LEN_W-1:0];
			end
			CMD_Q1_DIV_B: begin
				div_start    = 1'b1;
				div_dividend = {{(DIV_W-PROD_W){1'b0}}, ij_q};
				div_divisor  = l_q[LEN_W-1:0];
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// pattern store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == CMD_DONE)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (cmd)
				CMD_LOAD:     s_q <= s_q & mask;
				CMD_INVERT:   s_q <= ~s_q & mask;
				CMD_ROT:      s_q <= rot_val;
				CMD_GEN_INIT: s_q <= len_mask(h_init);
				CMD_MOVE:     s_q <= move_last(s_q, n, pos_move);
				CMD_FIN_MOVE: s_q <= move_last(s_q, n, pos_fin);
				default:      s_q <= s_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LOAD: begin
				op_q   <= op_t'(in_op);
				hits_q <= in_hits;
				idx_q  <= in_step_index;
				amt_q  <= in_shift_amount;
				trig_q <= 1'b0;
			end
			CMD_READ: trig_q <= s_q[div_r[IDX_W-1:0]];
			CMD_GEN_INIT: begin
				h_q   <= h_init;
				len_q <= n;
				j_q   <= LEN_W'(J_INIT);
				k_q   <= '0;
			end
			CMD_PASSES: passes_q <= div_q[LEN_W-1:0] - 1'b1;
			CMD_PASS_BEGIN, CMD_FIN_BEGIN: begin
				l_q <= l_val;
				i_q <= '0;
			end
			CMD_MOVE: begin
				if (l_q < h_s)
					h_q <= h_q - 1'b1;
				len_q <= len_q - 1'b1;
				i_q   <= i_q + 1'b1;
			end
			CMD_PASS_END: begin
				j_q <= j_q + 1'b1;
				k_q <= k_q + 1'b1;
			end
			CMD_PROD1: ij_q <= ij_val;
			CMD_PROD2: ijh_q <= ijh_val[DIV_W-1:0];
			CMD_Q1_DIV_B: q1_q <= div_q;
			CMD_FIN_MOVE: begin
				len_q <= len_q - 1'b1;
				i_q   <= i_q + 1'b1;
			end
			CMD_DONE: begin
				out_trigger_q <= trig_q;
				out_pattern_q <= s_q;
			end
			default: trig_q <= trig_q;
		endcase
	end

	always_comb begin
		status.op        = op_q;
		status.h_trivial = (h_q == '0) || (h_q == len_q);
		status.pass_more = k_q < passes_q;
		status.i_lt_l    = $signed({1'b0, i_q}) < l_q;
		status.div_done  = div_done;
		status.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_trigger = out_trigger_q;
	assign out_pattern = out_pattern_q;

endmodule

/* rtl/etp_ctrl.sv */
// controller state machine sequencing the datapath for each item
module etp_ctrl import etp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd      = CMD_LOAD;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (status.op)
					OP_GEN: state_nx = S_GEN_INIT;
					OP_READ: begin
						cmd      = CMD_DIV_IDX;
						state_nx = S_IDX_WAIT;
					end
					OP_ROT: begin
						cmd      = CMD_DIV_AMT;
						state_nx = S_AMT_WAIT;
					end
					OP_INV: begin
						cmd      = CMD_INVERT;
						state_nx = S_DONE;
					end
					default: state_nx = S_DONE;
				endcase
			end
			S_IDX_WAIT: begin
				if (status.div_done) begin
					cmd      = CMD_READ;
					state_nx = S_DONE;
				end
			end
			S_AMT_WAIT: begin
				if (status.div_done) begin
					cmd      = CMD_ROT;
					state_nx = S_DONE;
				end
			end
			S_GEN_INIT: begin
				cmd      = CMD_GEN_INIT;
				state_nx = S_GEN_CHECK;
			end
			S_GEN_CHECK: begin
				if (status.h_trivial) begin
					state_nx = S_DONE;
				end else begin
					cmd      = CMD_DIV_M;
					state_nx = S_M_WAIT;
				end
			end
			S_M_WAIT: begin
				if (status.div_done) begin
					cmd      = CMD_PASSES;
					state_nx = S_PASS_CHECK;
				end
			end
			S_PASS_CHECK: begin
				if (status.pass_more) begin
					cmd      = CMD_PASS_BEGIN;
					state_nx = S_MOVE;
				end else begin
					cmd      = CMD_FIN_BEGIN;
					state_nx = S_FIN_CHECK;
				end
			end
			S_MOVE: begin
				if (status.i_lt_l) begin
					cmd = CMD_MOVE;
				end else begin
					cmd      = CMD_PASS_END;
					state_nx = S_PASS_CHECK;
				end
			end
			S_FIN_CHECK: begin
				if (status.i_lt_l) begin
					cmd      = CMD_PROD1;
					state_nx = S_PROD2;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_PROD2: begin
				cmd      = CMD_PROD2;
				state_nx = S_DIV_A;
			end
			S_DIV_A: begin
				cmd      = CMD_DIV_A;
				state_nx = S_WAIT_A;
			end
			S_WAIT_A: begin
				if (status.div_done) begin
					cmd      = CMD_Q1_DIV_B;
					state_nx = S_WAIT_B;
				end
			end
			S_WAIT_B: begin
				if (status.div_done) begin
					cmd      = CMD_FIN_MOVE;
					state_nx = S_FIN_CHECK;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd      = CMD_DONE;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

endmodule
